@@ src/srq_pkg.sv @@
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants for the sorted relevance queue
// Queue depth, derived widths, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 16;
  localparam int KEY_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the incoming word
    logic do_insert;   // shift tail back, write new entry
    logic do_pop;      // shift all entries forward, report head
    logic set_drop;    // insert refused, queue full
    logic load_result; // update result registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } stat_t;

endpackage

@@ src/srq_ctrl.sv @@
// ----------------------------------------------------------------------------
// srq_ctrl: sequencing state machine
// Accepts a word, issues the insert/pop/drop command, then strobes the result.
// ----------------------------------------------------------------------------
module srq_ctrl
  import srq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:   state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: begin
        cmd.load_result = 1'b1;
        cmd.do_insert   = !stat.is_pop && !stat.full;
        cmd.set_drop    = !stat.is_pop && stat.full;
        cmd.do_pop      = stat.is_pop && !stat.empty;
      end
      S_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/srq_datapath.sv @@
// ----------------------------------------------------------------------------
// srq_datapath: row of sorted cells plus result registers
// Every cell compares its key to the new key in parallel; an insert shifts
// the tail back one cell, a pop shifts everything forward one cell.
// ----------------------------------------------------------------------------
module srq_datapath
  import srq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               op,
  input  logic [ID_W-1:0]    doc_id,
  input  logic [KEY_W-1:0]   relevance,
  output stat_t              stat,
  output logic               out_valid,
  output logic [ID_W-1:0]    out_doc_id,
  output logic [KEY_W-1:0]   out_relevance,
  output logic               insert_dropped,
  output logic [CNT_W-1:0]   entry_count
);

  logic [KEY_W-1:0] cell_key      [DEPTH];
  logic [ID_W-1:0]  cell_id       [DEPTH];
  logic [KEY_W-1:0] cell_key_next [DEPTH];
  logic [ID_W-1:0]  cell_id_next  [DEPTH];
  logic [DEPTH-1:0] ahead;  // cell holds a valid key strictly above the new one

  logic             in_op;
  logic [ID_W-1:0]  in_id;
  logic [KEY_W-1:0] in_key;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op  <= op;
      in_id  <= doc_id;
      in_key <= relevance;
    end
  end

  assign stat.is_pop = (in_op == OP_POP);
  assign stat.full   = (count == CNT_W'(DEPTH));
  assign stat.empty  = (count == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ahead[i] = (CNT_W'(i) < count) && (cell_key[i] > in_key);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_key_next[i] = cell_key[i];
      cell_id_next[i]  = cell_id[i];
      if (cmd.do_insert && !ahead[i]) begin
        if (i == 0 || ahead[(i == 0) ? 0 : i - 1]) begin
          cell_key_next[i] = in_key;
          cell_id_next[i]  = in_id;
        end else begin
          cell_key_next[i] = cell_key[(i == 0) ? 0 : i - 1];
          cell_id_next[i]  = cell_id[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.do_pop && i < DEPTH - 1) begin
        cell_key_next[i] = cell_key[(i < DEPTH - 1) ? i + 1 : i];
        cell_id_next[i]  = cell_id[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_key[i] <= cell_key_next[i];
      cell_id[i]  <= cell_id_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_valid      <= cmd.do_pop;
      out_doc_id     <= cmd.do_pop ? cell_id[0] : '0;
      out_relevance  <= cmd.do_pop ? cell_key[0] : '0;
      insert_dropped <= cmd.set_drop;
    end
  end

  assign entry_count = count;

endmodule

@@ src/sorted_relevance_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_relevance_queue_top: bounded queue in descending relevance order
// Insert places an entry ahead of equal or lower keys; pop returns the head.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  command  | start / busy        | op, doc_id, relevance
//  result   | done (1-cycle)      | out_valid, out_doc_id, out_relevance,
//           |                     | insert_dropped, entry_count
//
//  Sequence: each word passes accept, cell update and result strobe in turn;
//  a new word can be accepted the cycle after done. In the cell update
//  all cells compare against the new key in parallel.
//  Reset: rst (sync) empties the queue; cell contents are left as they are.
//  Stalls: the receiver cannot stall; done lasts exactly one cycle and
//  busy stays high from accept until done.
//
module sorted_relevance_queue_top
  import srq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [ID_W-1:0]    doc_id,
  input  logic [KEY_W-1:0]   relevance,
  output logic               done,
  output logic               out_valid,
  output logic [ID_W-1:0]    out_doc_id,
  output logic [KEY_W-1:0]   out_relevance,
  output logic               insert_dropped,
  output logic [CNT_W-1:0]   entry_count
);

  cmd_t  cmd;   // controller commands
  stat_t stat;  // datapath status (op kind, full, empty)

  // Controller: idle -> exec (cells update, results latched) -> report.
  srq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: sorted cell row, entry count and result registers.
  srq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (op),
    .doc_id         (doc_id),
    .relevance      (relevance),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_doc_id     (out_doc_id),
    .out_relevance  (out_relevance),
    .insert_dropped (insert_dropped),
    .entry_count    (entry_count)
  );

endmodule

@@ src/srq_checker.sv @@
// ----------------------------------------------------------------------------
// srq_checker: port-level checks for the sorted relevance queue
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module srq_checker
  import srq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             out_valid,
  input logic             insert_dropped,
  input logic [CNT_W-1:0] entry_count
);

  // an accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result can never be both a popped entry and a dropped insert
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(out_valid && insert_dropped))
    else $error("pop and drop flagged together");

  // a drop only happens with a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    done && insert_dropped |-> entry_count == CNT_W'(DEPTH))
    else $error("drop reported while not full");

  // after a successful pop the queue cannot be full
  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    done && out_valid |-> entry_count < CNT_W'(DEPTH))
    else $error("count full after pop");

  // count never exceeds depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

endmodule

bind sorted_relevance_queue_top srq_checker u_srq_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .out_valid      (out_valid),
  .insert_dropped (insert_dropped),
  .entry_count    (entry_count)
);
